@@ rtl/irpw_pkg.sv @@
// ---------------------------------------------------------------------------
// irpw_pkg: shared types and constants of the pulse-width IR frame sender
// Holds the beat payload structs, the register map and the register
// reset values.
// ---------------------------------------------------------------------------
package irpw_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PULSE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PULSE = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_GAP  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_PULSE   = 8'd3;

  // Register reset values, in ticks
  localparam logic [15:0] LONG_PULSE_RST  = 16'd1600;
  localparam logic [15:0] SHORT_PULSE_RST = 16'd800;
  localparam logic [15:0] REPEAT_GAP_RST  = 16'd3000;
  localparam logic [15:0] END_PULSE_RST   = 16'd400;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] player_num;
    logic [15:0] payload;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic rejected;
  } out_item_t;

  typedef struct packed {
    logic [15:0] long_pulse_ticks;
    logic [15:0] short_pulse_ticks;
    logic [15:0] repeat_gap_ticks;
    logic [15:0] end_pulse_ticks;
  } cfg_regs_t;

endpackage

@@ rtl/irpw_engine.sv @@
// ---------------------------------------------------------------------------
// irpw_engine: frame sequencer of the pulse-width IR sender
// Holds the pending request slot and the phase / bit / half / timer state;
// computes one result per step from the current state and the step's item.
// ---------------------------------------------------------------------------
module irpw_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  irpw_pkg::in_item_t   item,
  input  irpw_pkg::cfg_regs_t  cfg,
  output irpw_pkg::out_item_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FRAME  = 3'd1,
    PH_GAP    = 3'd2,
    PH_REPEAT = 3'd3,
    PH_END    = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_pos_r, bit_pos_nxt;
  logic        high_r, high_nxt;
  logic [15:0] time_r, time_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] pend_player_r, pend_player_nxt;
  logic [15:0] pend_payload_r, pend_payload_nxt;

  // A zero count lasts one tick.
  function automatic logic [15:0] dur(input logic [15:0] t);
    dur = (t == 16'd0) ? 16'd1 : t;
  endfunction

  function automatic logic level_of(input phase_t ph, input logic hi);
    logic lvl;
    lvl = 1'b0;
    if (ph == PH_FRAME || ph == PH_REPEAT) begin
      lvl = hi;
    end else if (ph == PH_END) begin
      lvl = 1'b1;
    end
    level_of = lvl;
  endfunction

  function automatic logic is_active(input phase_t ph);
    is_active = (ph == PH_FRAME) || (ph == PH_GAP) || (ph == PH_REPEAT) || (ph == PH_END);
  endfunction

  always_comb begin
    logic [3:0] bp_dec;
    phase_nxt        = phase_r;
    bit_pos_nxt      = bit_pos_r;
    high_nxt         = high_r;
    time_nxt         = time_r;
    frame_nxt        = frame_r;
    pend_nxt         = pend_r;
    pend_player_nxt  = pend_player_r;
    pend_payload_nxt = pend_payload_r;
    res              = '0;
    bp_dec           = 4'(bit_pos_r - 4'd1);

    if (item.command == irpw_pkg::CMD_SEND) begin
      // Overwrite the slot; report the line as it stands.
      pend_nxt         = 1'b1;
      pend_player_nxt  = item.player_num;
      pend_payload_nxt = item.payload;
      res.ir_level     = level_of(phase_r, high_r);
      res.busy_res     = is_active(phase_r);
    end else begin
      if (!is_active(phase_r)) begin
        phase_nxt = PH_IDLE;
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (pend_player_r[15:5] != 11'd0 || pend_payload_r[15:5] != 11'd0) begin
            res.rejected = 1'b1;
          end else begin
            frame_nxt   = {1'b1, pend_payload_r[4:0] ^ pend_player_r[4:0],
                           pend_payload_r[4:0], pend_player_r[4:0]};
            phase_nxt   = PH_FRAME;
            bit_pos_nxt = 4'd15;
            high_nxt    = 1'b1;
            // Start bit is always a one.
            time_nxt    = dur(cfg.long_pulse_ticks);
          end
        end
      end

      if (phase_nxt != PH_IDLE) begin
        res.ir_level = level_of(phase_nxt, high_nxt);
        res.busy_res = 1'b1;
        time_nxt     = 16'(time_nxt - 16'd1);
        if (time_nxt == 16'd0) begin
          unique case (phase_nxt)
            PH_FRAME, PH_REPEAT: begin
              if (high_nxt) begin
                high_nxt = 1'b0;
                time_nxt = dur(frame_nxt[bit_pos_nxt] ? cfg.short_pulse_ticks
                                                      : cfg.long_pulse_ticks);
              end else if (bit_pos_nxt == 4'd0) begin
                if (phase_nxt == PH_FRAME) begin
                  phase_nxt = PH_GAP;
                  time_nxt  = dur(cfg.repeat_gap_ticks);
                end else begin
                  phase_nxt = PH_END;
                  time_nxt  = dur(cfg.end_pulse_ticks);
                end
              end else begin
                // Only reached from a running frame, so bit_pos_nxt is bit_pos_r.
                bit_pos_nxt = bp_dec;
                high_nxt    = 1'b1;
                time_nxt    = dur(frame_nxt[bp_dec] ? cfg.long_pulse_ticks
                                                    : cfg.short_pulse_ticks);
              end
            end
            PH_GAP: begin
              phase_nxt   = PH_REPEAT;
              bit_pos_nxt = 4'd15;
              high_nxt    = 1'b1;
              time_nxt    = dur(frame_nxt[15] ? cfg.long_pulse_ticks
                                              : cfg.short_pulse_ticks);
            end
            default: begin
              phase_nxt = PH_IDLE;
              time_nxt  = 16'd0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_pos_r      <= 4'd0;
      high_r         <= 1'b0;
      time_r         <= 16'd0;
      frame_r        <= 16'd0;
      pend_r         <= 1'b0;
      pend_player_r  <= 16'd0;
      pend_payload_r <= 16'd0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      bit_pos_r      <= bit_pos_nxt;
      high_r         <= high_nxt;
      time_r         <= time_nxt;
      frame_r        <= frame_nxt;
      pend_r         <= pend_nxt;
      pend_player_r  <= pend_player_nxt;
      pend_payload_r <= pend_payload_nxt;
    end
  end

endmodule

@@ rtl/ir_pulse_width_frame_sender.sv @@
// Output: each result beat is registered in the output register, or in the skid entry if stalled.
// Throughput: one input beat per cycle while in_stall is low; each beat (tick
// or send request) is handled in a single pass through the sequencer logic,
// while a two-entry result buffer (output register plus skid) absorbs a stalled output.
// Reset: synchronous, active low; clears the sequencer to idle with no pending
// request, empties the result buffer and loads the timing registers' defaults.
// ---------------------------------------------------------------------------
// ir_pulse_width_frame_sender: pulse-width infrared frame transmitter
// A send request parks a player id and a data value in a one-deep slot; an idle
// tick launches it, if both are at most 31, as a 16-bit frame sent twice with a gap,
// then a closing high pulse. Each input beat yields exactly one result beat.
// ---------------------------------------------------------------------------
module ir_pulse_width_frame_sender (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  irpw_pkg::in_item_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output irpw_pkg::out_item_t                  out_data,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [irpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  irpw_pkg::cfg_regs_t  cfg_r;
  irpw_pkg::out_item_t  res;
  irpw_pkg::out_item_t  out_data_r;
  irpw_pkg::out_item_t  skid_r;
  logic                 out_valid_r;
  logic                 skid_valid_r;
  logic                 in_take;
  logic                 out_take;

  // Stall the input only when both result slots are full; the skid entry
  // only fills while the output register is held by a stalled receiver.
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: state advances exactly once per accepted input beat.
  irpw_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_take),
    .item    (in_data),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r             <= 1'b0;
      skid_valid_r            <= 1'b0;
      cfg_r.long_pulse_ticks  <= irpw_pkg::LONG_PULSE_RST;
      cfg_r.short_pulse_ticks <= irpw_pkg::SHORT_PULSE_RST;
      cfg_r.repeat_gap_ticks  <= irpw_pkg::REPEAT_GAP_RST;
      cfg_r.end_pulse_ticks   <= irpw_pkg::END_PULSE_RST;
    end else begin
      // Register writes; drop writes to indexes beyond the map.
      if (cfg_we) begin
        unique case (cfg_index)
          irpw_pkg::REG_LONG_PULSE:  cfg_r.long_pulse_ticks  <= cfg_wdata;
          irpw_pkg::REG_SHORT_PULSE: cfg_r.short_pulse_ticks <= cfg_wdata;
          irpw_pkg::REG_REPEAT_GAP:  cfg_r.repeat_gap_ticks  <= cfg_wdata;
          irpw_pkg::REG_END_PULSE:   cfg_r.end_pulse_ticks   <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_take || !out_valid_r) begin
        // Output register frees up: drain the skid first, else take the new beat.
        if (skid_valid_r) begin
          out_data_r   <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (in_take) begin
          out_data_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_take) begin
        // Output held: park the fresh result in the skid entry.
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

@@ bench/irpw_emitter_monitor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irpw_emitter_monitor: emitter-level predictor and result checker
// Watches the input, result and register-write ports of the frame sender,
// works out the emitter sample each input beat should yield and compares
// every result beat against the oldest outstanding sample.
// ---------------------------------------------------------------------------
module irpw_emitter_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  irpw_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  irpw_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [irpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [irpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  beats_checked,
  output int                                  frames_started,
  output int                                  requests_dropped
);

  localparam logic [15:0] FIELD_LIMIT = 16'd31;
  localparam logic [3:0]  FRAME_MSB   = 4'd15;

  typedef enum logic [2:0] {
    TX_IDLE   = 3'd0,
    TX_FRAME  = 3'd1,
    TX_GAP    = 3'd2,
    TX_REPEAT = 3'd3,
    TX_END    = 3'd4
  } tx_phase_t;

  // Predicted sender state
  irpw_pkg::cfg_regs_t timing;
  tx_phase_t           tx_phase;
  logic [3:0]          bit_pos;
  logic                high_half;
  logic [15:0]         ticks_left;
  logic [15:0]         frame_word;
  logic                req_held;
  logic [15:0]         req_player;
  logic [15:0]         req_payload;

  irpw_pkg::out_item_t emitter_q[$];
  irpw_pkg::out_item_t want;
  irpw_pkg::out_item_t predicted;
  int                  mismatches = 0;
  int                  n_checked  = 0;
  int                  n_started  = 0;
  int                  n_dropped  = 0;

  function automatic logic [15:0] seg_len(input logic [15:0] t);
    return (t == '0) ? 16'd1 : t;
  endfunction

  function automatic logic sending();
    return tx_phase != TX_IDLE;
  endfunction

  function automatic logic emitter_on();
    case (tx_phase)
      TX_FRAME, TX_REPEAT: return high_half;
      TX_END:              return 1'b1;
      default:             return 1'b0;
    endcase
  endfunction

  task automatic load_high_half();
    high_half  = 1'b1;
    ticks_left = seg_len(frame_word[bit_pos] ? timing.long_pulse_ticks
                                             : timing.short_pulse_ticks);
  endtask

  task automatic next_segment();
    case (tx_phase)
      TX_FRAME, TX_REPEAT: begin
        if (high_half) begin
          high_half  = 1'b0;
          ticks_left = seg_len(frame_word[bit_pos] ? timing.short_pulse_ticks
                                                   : timing.long_pulse_ticks);
        end else if (bit_pos == '0) begin
          if (tx_phase == TX_FRAME) begin
            tx_phase   = TX_GAP;
            ticks_left = seg_len(timing.repeat_gap_ticks);
          end else begin
            tx_phase   = TX_END;
            ticks_left = seg_len(timing.end_pulse_ticks);
          end
        end else begin
          bit_pos = bit_pos - 4'd1;
          load_high_half();
        end
      end
      TX_GAP: begin
        tx_phase = TX_REPEAT;
        bit_pos  = FRAME_MSB;
        load_high_half();
      end
      default: begin
        tx_phase   = TX_IDLE;
        ticks_left = '0;
      end
    endcase
  endtask

  // Advance the predicted sender by one input beat and return its emitter sample
  task automatic emit_for_beat(input irpw_pkg::in_item_t b, output irpw_pkg::out_item_t r);
    r = '0;
    if (b.command == irpw_pkg::CMD_SEND) begin
      req_player  = b.player_num;
      req_payload = b.payload;
      req_held    = 1'b1;
      r.ir_level  = emitter_on();
      r.busy_res  = sending();
    end else begin
      if (!sending() && req_held) begin
        req_held = 1'b0;
        if (req_player > FIELD_LIMIT || req_payload > FIELD_LIMIT) begin
          r.rejected = 1'b1;
          n_dropped++;
        end else begin
          frame_word = {1'b1, req_payload[4:0] ^ req_player[4:0],
                        req_payload[4:0], req_player[4:0]};
          tx_phase   = TX_FRAME;
          bit_pos    = FRAME_MSB;
          load_high_half();
          n_started++;
        end
      end
      if (sending()) begin
        r.ir_level = emitter_on();
        r.busy_res = 1'b1;
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == '0) next_segment();
      end
    end
  endtask

  task automatic check_field(input string field, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timing      = '{irpw_pkg::LONG_PULSE_RST, irpw_pkg::SHORT_PULSE_RST,
                      irpw_pkg::REPEAT_GAP_RST, irpw_pkg::END_PULSE_RST};
      tx_phase    = TX_IDLE;
      bit_pos     = '0;
      high_half   = 1'b0;
      ticks_left  = '0;
      frame_word  = '0;
      req_held    = 1'b0;
      req_player  = '0;
      req_payload = '0;
      emitter_q.delete();
    end else begin
      // Retire first: a result never leaves in the cycle its input beat is taken
      if (out_valid && !out_stall) begin
        if (emitter_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %b",
                   $time, out_data);
          mismatches++;
        end else begin
          want = emitter_q.pop_front();
          check_field("ir_level", want.ir_level, out_data.ir_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("rejected", want.rejected, out_data.rejected);
          n_checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          irpw_pkg::REG_LONG_PULSE:  timing.long_pulse_ticks  = cfg_wdata;
          irpw_pkg::REG_SHORT_PULSE: timing.short_pulse_ticks = cfg_wdata;
          irpw_pkg::REG_REPEAT_GAP:  timing.repeat_gap_ticks  = cfg_wdata;
          irpw_pkg::REG_END_PULSE:   timing.end_pulse_ticks   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        emit_for_beat(in_data, predicted);
        emitter_q.push_back(predicted);
      end
    end
    fail_count       <= mismatches;
    pending          <= emitter_q.size();
    beats_checked    <= n_checked;
    frames_started   <= n_started;
    requests_dropped <= n_dropped;
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pulse-width IR frame sender
// Drives send requests and ticks through the valid/stall input channel under
// changing timing registers and idle patterns; the emitter monitor predicts
// and checks every result beat.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int          TIMEOUT_NS   = 1_000_000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          BEATS_PER_SETTING = 32;
  localparam logic [15:0] FIELD_LIMIT  = 16'd31;
  localparam logic [15:0] TICKS_MAX    = 16'hFFFF;
  // Unmapped register indexes: writes there must leave the timing untouched
  localparam logic [irpw_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = irpw_pkg::REG_END_PULSE + 1'b1;
  localparam logic [irpw_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = '1;

  // Idle patterns: sender gap and receiver stall percentages per mode
  localparam int MODE_SLOW_SINK = 0;
  localparam int MODE_SLOW_SRC  = 1;
  localparam int MODE_NO_IDLE   = 2;
  localparam int SRC_IDLE_PCT[3]  = '{8, 76, 0};
  localparam int SINK_STALL_PCT[3] = '{76, 8, 0};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  irpw_pkg::in_item_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  irpw_pkg::out_item_t  out_data;
  logic                 cfg_we    = 1'b0;
  logic [irpw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [irpw_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending;
  int beats_checked;
  int frames_started;
  int requests_dropped;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  ir_pulse_width_frame_sender DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  irpw_emitter_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending),
    .beats_checked    (beats_checked),
    .frames_started   (frames_started),
    .requests_dropped (requests_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: stall at random, at the rate of the current mode
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic set_mode(input int mode);
    src_idle_pct   = SRC_IDLE_PCT[mode];
    sink_stall_pct = SINK_STALL_PCT[mode];
  endtask

  // Offer one beat, optionally after a random gap, and hold it until taken.
  // The payload only changes once the previous beat has been accepted.
  task automatic put_beat(input irpw_pkg::in_item_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_request(input logic [15:0] player, input logic [15:0] data);
    irpw_pkg::in_item_t b;
    b.command    = irpw_pkg::CMD_SEND;
    b.player_num = player;
    b.payload    = data;
    put_beat(b);
  endtask

  // Tick beats carry junk in the request fields; the sender must ignore it
  task automatic put_ticks(input int n);
    irpw_pkg::in_item_t b;
    for (int i = 0; i < n; i++) begin
      b.command    = irpw_pkg::CMD_TICK;
      b.player_num = 16'($urandom());
      b.payload    = 16'($urandom());
      put_beat(b);
    end
  endtask

  // Drop valid and wait until every predicted result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [irpw_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [irpw_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] long_t, input logic [15:0] short_t,
                            input logic [15:0] gap_t, input logic [15:0] end_t);
    settle();
    set_reg(irpw_pkg::REG_LONG_PULSE, long_t);
    set_reg(irpw_pkg::REG_SHORT_PULSE, short_t);
    set_reg(irpw_pkg::REG_REPEAT_GAP, gap_t);
    set_reg(irpw_pkg::REG_END_PULSE, end_t);
  endtask

  // Mostly ticks; a request now and then, in range less than half the time so frames go out,
  // and otherwise with one or both fields over the limit
  function automatic irpw_pkg::in_item_t random_item();
    irpw_pkg::in_item_t b;
    int                 pick;
    b.command    = irpw_pkg::CMD_TICK;
    b.player_num = 16'($urandom());
    b.payload    = 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 8) begin
      b.command = irpw_pkg::CMD_SEND;
      case ($urandom_range(4))
        0:       b.player_num = 16'($urandom_range(FIELD_LIMIT));
        1:       b.payload    = 16'($urandom_range(FIELD_LIMIT));
        2:       ;
        default: begin
          b.player_num = 16'($urandom_range(FIELD_LIMIT));
          b.payload    = 16'($urandom_range(FIELD_LIMIT));
        end
      endcase
    end
    return b;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, receiver mostly stalled
    set_mode(MODE_SLOW_SINK);
    // Zero in every register: each segment must still last one tick
    set_timing('0, '0, '0, '0);
    put_ticks(1);
    // Out-of-range player, then out-of-range payload: both dropped and flagged
    put_request(TICKS_MAX, '0);
    put_ticks(1);
    put_request('0, TICKS_MAX);
    put_ticks(1);
    // A later request overwrites a bad pending one; the all-zero frame goes out
    put_request(FIELD_LIMIT + 1'b1, 16'd5);
    put_request('0, '0);
    put_ticks(4);
    // Request while busy: parked until the transmission is over
    put_request(FIELD_LIMIT, FIELD_LIMIT);
    put_ticks(140);
    // Writes to unmapped indexes must not disturb the timing
    settle();
    set_reg(REG_SPARE_LO, 16'd1);
    set_reg(REG_SPARE_HI, TICKS_MAX);
    set_timing(16'd2, 16'd1, 16'd3, 16'd2);
    put_request(16'd21, 16'd10);
    // Lengthen the short half mid-send: it applies from the next segment load
    put_ticks(20);
    settle();
    set_reg(irpw_pkg::REG_SHORT_PULSE, 16'd2);
    put_ticks(140);

    // Random part: each idle mode in turn, a few small timing settings each
    for (int mode = MODE_SLOW_SINK; mode <= MODE_NO_IDLE; mode++) begin
      set_mode(mode);
      for (int s = 0; s < 3; s++) begin
        set_timing(16'($urandom_range(3)), 16'($urandom_range(3)),
                   16'($urandom_range(3)), 16'($urandom_range(3)));
        if ($urandom_range(1) == 0) begin
          set_reg(irpw_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  16'($urandom()));
        end
        for (int k = 0; k < BEATS_PER_SETTING; k++) put_beat(random_item());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result beats: %0d frames sent, %0d requests dropped,",
             beats_checked, frames_started, requests_dropped);
    $display("timing from zero to small counts with a mid-send change, "
             , "under three idle patterns");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
